// ===== hw/rtl/fsa_pkg.sv =====
`timescale 1ns / 1ps

package fsa_pkg;

  localparam int SLOT_W = 12;
  localparam int CFG_W  = 18;
  localparam int CNT_W  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] MIN_ITEM_BYTES = CFG_W'(8);
  localparam logic [CFG_W-1:0] ITEM_BYTES_RST = CFG_W'(8);

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_RELEASED  = 3'd1,
    ST_NULL      = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_BADFREE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_CARVE,
    S_ADD
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot_given;
    logic              has_slot;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_granted;
    logic [CNT_W-1:0]  allocs_seen;
    logic [CNT_W-1:0]  frees_seen;
    logic [CNT_W-1:0]  carved_bytes;
  } result_t;

endpackage

// ===== hw/rtl/fsa_ram.sv =====
`timescale 1ns / 1ps

module fsa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/fsa_div.sv =====
`timescale 1ns / 1ps

// Restoring divider: slots per chunk = CHUNK_BYTES / size, one quotient bit
// per cycle, result capped at SLOTS.
module fsa_div #(
  parameter int SLOTS       = 4096,
  parameter int CHUNK_BYTES = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [fsa_pkg::CFG_W-1:0]     divisor,
  output logic                          running,
  output logic [$clog2(SLOTS+1)-1:0]    per_cap
);

  localparam int SW = fsa_pkg::CFG_W;
  localparam int NQ = $clog2(CHUNK_BYTES + 1);
  localparam int DW = $clog2(SLOTS + 1);
  localparam int MW = (NQ > DW) ? NQ : DW;
  localparam int KW = $clog2(NQ + 1);

  logic [SW-1:0] rem;
  logic [NQ-1:0] dvd;
  logic [NQ-1:0] quo;
  logic [KW-1:0] cnt;
  logic [SW:0]   trial;
  logic          fits;

  assign trial   = {rem, dvd[NQ-1]};
  assign fits    = trial >= {1'b0, divisor};
  assign running = cnt != '0;
  assign per_cap = (MW'(quo) > MW'(SLOTS)) ? DW'(SLOTS) : DW'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (go) begin
      cnt <= KW'(NQ);
    end else if (running) begin
      cnt <= cnt - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      dvd <= NQ'(CHUNK_BYTES);
      quo <= '0;
    end else if (running) begin
      rem <= fits ? SW'(trial - {1'b0, divisor}) : SW'(trial);
      dvd <= {dvd[NQ-2:0], 1'b0};
      quo <= {quo[NQ-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/fixed_size_slot_allocator.sv =====
`timescale 1ns / 1ps
// Timing: free, null free and alloc from the open chunk raise done in the cycle
//   after accept; a pop passes through S_POP, an exhausted alloc through S_CARVE,
//   and an alloc that carves a chunk through S_CARVE and S_ADD before done. Busy
//   holds off new words in those states and while the slots-per-chunk division runs.
// Reset: synchronous, clears counters and cursors, stack RAM is not cleared, and the
//   divider runs once after reset with busy high. Results cannot be stalled.

module fixed_size_slot_allocator #(
  parameter int SLOTS       = 4096,
  parameter int CHUNK_BYTES = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  fsa_pkg::cmd_t                 cmd,
  // result strobe, one cycle per word
  output logic                          done,
  output fsa_pkg::result_t              result,
  // configuration: item_bytes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fsa_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DW   = $clog2(SLOTS + 1);
  localparam int AW   = $clog2(SLOTS);
  localparam int SLW  = fsa_pkg::SLOT_W;
  localparam int CNW  = fsa_pkg::CNT_W;
  localparam int CW   = (DW > SLW) ? DW : SLW;
  localparam int PW   = DW + fsa_pkg::CFG_W;
  localparam int SUMW = ((PW > CNW) ? PW : CNW) + 1;

  // Configuration register; a write restarts the per-chunk division.
  logic [fsa_pkg::CFG_W-1:0] item_bytes;
  logic [fsa_pkg::CFG_W-1:0] size;
  logic                      cfg_fire;
  logic                      kick;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign size      = (item_bytes < fsa_pkg::MIN_ITEM_BYTES) ? fsa_pkg::MIN_ITEM_BYTES
                                                            : item_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_bytes <= fsa_pkg::ITEM_BYTES_RST;
      kick       <= 1'b1;
    end else begin
      kick <= 1'b0;
      if (cfg_fire) begin
        item_bytes <= cfg_data;
      end
    end
  end

  logic          div_running;
  logic [DW-1:0] per_cap;

  fsa_div #(
    .SLOTS       (SLOTS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (kick || cfg_fire),
    .divisor (size),
    .running (div_running),
    .per_cap (per_cap)
  );

  // Allocator state
  fsa_pkg::state_t   state, state_next;
  logic [DW-1:0]     depth, depth_next;
  logic [DW-1:0]     cursor, cursor_next;
  logic [DW-1:0]     limit, limit_next;
  logic [CNW-1:0]    alloc_total, alloc_total_next;
  logic [CNW-1:0]    free_total, free_total_next;
  logic [CNW-1:0]    byte_total, byte_total_next;
  logic [PW-1:0]     prod, prod_next;
  fsa_pkg::status_t  res_status, res_status_next;
  logic [SLW-1:0]    res_slot, res_slot_next;
  logic              done_next;

  // Freed-slot stack RAM. A push writes at the accept edge and a pop reads at a later
  // accept edge, so the two never touch the same entry in one cycle.
  logic              ram_we, ram_re;
  logic [SLW-1:0]    ram_rdata;

  fsa_ram #(
    .WIDTH (SLW),
    .DEPTH (SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(depth)),
    .wdata (cmd.slot_given),
    .re    (ram_re),
    .raddr (AW'(depth - DW'(1))),
    .rdata (ram_rdata)
  );

  logic          accept;
  logic [DW-1:0] room;
  logic [DW-1:0] per;
  logic [SUMW-1:0] byte_sum;

  assign busy     = (state != fsa_pkg::S_IDLE) || div_running || kick;
  assign accept   = start && !busy;
  assign room     = DW'(SLOTS) - limit;
  assign per      = (per_cap < room) ? per_cap : room;
  assign byte_sum = SUMW'(byte_total) + SUMW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fsa_pkg::S_IDLE;
      depth       <= '0;
      cursor      <= '0;
      limit       <= '0;
      alloc_total <= '0;
      free_total  <= '0;
      byte_total  <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      depth       <= depth_next;
      cursor      <= cursor_next;
      limit       <= limit_next;
      alloc_total <= alloc_total_next;
      free_total  <= free_total_next;
      byte_total  <= byte_total_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    prod       <= prod_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
  end

  always_comb begin
    state_next       = state;
    depth_next       = depth;
    cursor_next      = cursor;
    limit_next       = limit;
    alloc_total_next = alloc_total;
    free_total_next  = free_total;
    byte_total_next  = byte_total;
    prod_next        = prod;
    res_status_next  = res_status;
    res_slot_next    = res_slot;
    done_next        = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;

    case (state)
      fsa_pkg::S_IDLE: begin
        if (accept) begin
          res_slot_next = '0;
          if (cmd.kind == fsa_pkg::KIND_ALLOC) begin
            if (alloc_total != fsa_pkg::CNT_MAX) begin
              alloc_total_next = alloc_total + CNW'(1);
            end
            if (depth != '0) begin
              // pop: read the top entry, data lands next cycle
              depth_next = depth - DW'(1);
              ram_re     = 1'b1;
              state_next = fsa_pkg::S_POP;
            end else if (cursor < limit) begin
              res_status_next = fsa_pkg::ST_GRANTED;
              res_slot_next   = SLW'(cursor);
              cursor_next     = cursor + DW'(1);
              done_next       = 1'b1;
            end else begin
              state_next = fsa_pkg::S_CARVE;
            end
          end else if (!cmd.has_slot) begin
            res_status_next = fsa_pkg::ST_NULL;
            done_next       = 1'b1;
          end else begin
            if (free_total != fsa_pkg::CNT_MAX) begin
              free_total_next = free_total + CNW'(1);
            end
            if (CW'(cmd.slot_given) >= CW'(limit) || depth == DW'(SLOTS)) begin
              res_status_next = fsa_pkg::ST_BADFREE;
            end else begin
              ram_we          = 1'b1;
              depth_next      = depth + DW'(1);
              res_status_next = fsa_pkg::ST_RELEASED;
            end
            done_next = 1'b1;
          end
        end
      end
      fsa_pkg::S_POP: begin
        res_status_next = fsa_pkg::ST_GRANTED;
        res_slot_next   = ram_rdata;
        done_next       = 1'b1;
        state_next      = fsa_pkg::S_IDLE;
      end
      fsa_pkg::S_CARVE: begin
        if (per == '0) begin
          // slot space used up, or slot larger than a chunk
          res_status_next = fsa_pkg::ST_EXHAUSTED;
          done_next       = 1'b1;
          state_next      = fsa_pkg::S_IDLE;
        end else begin
          limit_next      = limit + per;
          prod_next       = PW'(per) * PW'(size);
          res_status_next = fsa_pkg::ST_GRANTED;
          res_slot_next   = SLW'(cursor);
          cursor_next     = cursor + DW'(1);
          state_next      = fsa_pkg::S_ADD;
        end
      end
      fsa_pkg::S_ADD: begin
        // fold the carved bytes in, saturating
        byte_total_next = (byte_sum > SUMW'(fsa_pkg::CNT_MAX)) ? fsa_pkg::CNT_MAX
                                                               : CNW'(byte_sum);
        done_next       = 1'b1;
        state_next      = fsa_pkg::S_IDLE;
      end
      default: begin
        state_next = fsa_pkg::S_IDLE;
      end
    endcase
  end

  // Counters are stable while the result word is on the strobe.
  assign result.status       = res_status;
  assign result.slot_granted = res_slot;
  assign result.allocs_seen  = alloc_total;
  assign result.frees_seen   = free_total;
  assign result.carved_bytes = byte_total;

endmodule

// ===== hw/rtl/fsa_chk.sv =====
`timescale 1ns / 1ps

module fsa_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input fsa_pkg::cmd_t             cmd,
  input logic                      done,
  input fsa_pkg::result_t          result,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [fsa_pkg::CFG_W-1:0] cfg_data
);

  // an accepted word either finishes next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither finished nor held busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == fsa_pkg::ST_GRANTED || result.status == fsa_pkg::ST_RELEASED
           || result.status == fsa_pkg::ST_NULL || result.status == fsa_pkg::ST_EXHAUSTED
           || result.status == fsa_pkg::ST_BADFREE))
    else $error("status code out of range");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != fsa_pkg::ST_GRANTED) |-> (result.slot_granted == '0))
    else $error("slot reported on a word that granted nothing");

  a_counts_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (result.allocs_seen >= $past(result.allocs_seen)
                  && result.frees_seen >= $past(result.frees_seen)
                  && result.carved_bytes >= $past(result.carved_bytes)))
    else $error("saturating counter went backward");

  // words taken on the command or configuration channel carry known bits
  a_known_words: assert property (@(posedge clk) disable iff (rst)
    ((start && !busy) || (cfg_valid && cfg_ready)) |-> !$isunknown({cmd, cfg_data}))
    else $error("unknown bits on an accepted word");

endmodule

bind fixed_size_slot_allocator fsa_chk u_fsa_chk (.*);
